// ===== hdl/ebrp_pkg.sv =====
package ebrp_pkg;

   // Parser phase codes
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_TEXT     = 4'd1,
      PH_LEN      = 4'd2,
      PH_NILWAIT  = 4'd3,
      PH_BODY     = 4'd4,
      PH_TRAIL_CR = 4'd5,
      PH_TRAIL_LF = 4'd6,
      PH_SKIP     = 4'd7
   } phase_type;

   // Reply type codes
   localparam logic [1:0] TY_SIMPLE  = 2'd0;
   localparam logic [1:0] TY_BULK    = 2'd1;
   localparam logic [1:0] TY_INTEGER = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_NIL = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   // EBCDIC characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h25;
   localparam logic [7:0] CH_PLUS   = 8'h4E;
   localparam logic [7:0] CH_DOLLAR = 8'h5B;
   localparam logic [7:0] CH_MINUS  = 8'h60;
   localparam logic [7:0] CH_COLON  = 8'h7A;
   localparam logic [7:0] CH_ZERO   = 8'hF0;
   localparam logic [7:0] CH_NINE   = 8'hF9;

   // One result item, without the payload count
   typedef struct packed {
      logic       is_status;
      logic [7:0] data_byte;
      logic [1:0] reply_type;
      logic [1:0] status;
      logic       last;
   } result_type;

endpackage

// ===== hdl/ebcdic_resp_reply_parser.sv =====
// The results of a reply byte appear on rsp_ in the cycle after its transfer.
// Throughput: one byte per cycle while rsp_ready is high; a byte that yields two results
// (a held CR flushed together with the next byte) holds the input while the two-entry
// result register drains.
// Reset (synchronous, active high): return to idle awaiting a type byte, empty results.
module ebcdic_resp_reply_parser #(
   parameter int MAX_LENGTH_CHARS = 9,
   parameter int LENGTH_WIDTH     = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_resp_byte,
   input  logic                    req_end_of_buffer,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_status,
   output logic [7:0]              rsp_data_byte,
   output logic [1:0]              rsp_reply_type,
   output logic [1:0]              rsp_status,
   output logic [LENGTH_WIDTH-1:0] rsp_payload_count,
   output logic                    rsp_last
);
   import ebrp_pkg::*;

   localparam int LCW = $clog2(MAX_LENGTH_CHARS + 3);
   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};
   localparam logic [LCW-1:0] LCNT_LIMIT = LCW'(MAX_LENGTH_CHARS);

   // Parser state
   phase_type               phase_ff, phase_in;
   logic                    hcr_ff, hcr_in;          // CR held until the next byte decides
   logic [1:0]              type_ff, type_in;
   logic [LENGTH_WIDTH-1:0] lval_ff, lval_in;        // bulk length value
   logic [LCW-1:0]          lcnt_ff, lcnt_in;        // length header characters seen
   logic                    lneg_ff, lneg_in;
   logic                    stop_ff, stop_in;        // a non-digit ended the digits
   logic [LENGTH_WIDTH-1:0] rem_ff, rem_in;          // bulk bytes still to stream
   logic [LENGTH_WIDTH-1:0] cnt_ff, cnt_in;          // payload bytes streamed

   // Two-entry result register
   result_type              slot0_ff, slot1_ff;
   logic [LENGTH_WIDTH-1:0] count0_ff, count1_ff;
   logic [1:0]              fill_ff;

   // Results of the byte on the input
   result_type              res_a, res_b;
   logic [LENGTH_WIDTH-1:0] count_a, count_b;
   logic [1:0]              res_n;
   logic                    decided;

   // Helpers
   logic [7:0]              b;
   logic                    at_end;
   phase_type               fin_phase;
   logic [LENGTH_WIDTH-1:0] cnt_inc, cnt_inc2;
   logic [LCW-1:0]          lcnt_p1, lcnt_p2;
   logic                    is_digit;
   logic [LENGTH_WIDTH+3:0] lval_mac;
   logic [LENGTH_WIDTH-1:0] lval_next;
   logic                    take, pop;

   assign b         = req_resp_byte;
   assign at_end    = req_end_of_buffer;
   assign fin_phase = at_end ? PH_IDLE : PH_SKIP;
   assign cnt_inc   = (cnt_ff != LEN_MAX) ? cnt_ff + 1'b1 : cnt_ff;
   assign cnt_inc2  = (cnt_inc != LEN_MAX) ? cnt_inc + 1'b1 : cnt_inc;
   assign lcnt_p1   = lcnt_ff + 1'b1;
   assign lcnt_p2   = lcnt_ff + 2'd2;
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);

   // Accumulate one decimal digit: value * 10 + digit, saturated
   assign lval_mac  = {lval_ff, 3'b000} + {2'b00, lval_ff, 1'b0} + (LENGTH_WIDTH + 4)'(b[3:0]);
   assign lval_next = (lval_mac > (LENGTH_WIDTH + 4)'(LEN_MAX)) ?
                      LEN_MAX : lval_mac[LENGTH_WIDTH-1:0];

   // Accept a byte once its results fit: result register empty or draining its last entry
   assign req_ready = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = (fill_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   // Next state and results of one byte
   always_comb begin
      phase_in = phase_ff;
      hcr_in   = hcr_ff;
      type_in  = type_ff;
      lval_in  = lval_ff;
      lcnt_in  = lcnt_ff;
      lneg_in  = lneg_ff;
      stop_in  = stop_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res_a    = '0;
      res_b    = '0;
      count_a  = '0;
      count_b  = '0;
      res_n    = 2'd0;
      decided  = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            // Start a fresh reply
            hcr_in  = 1'b0;
            lval_in = '0;
            lcnt_in = '0;
            lneg_in = 1'b0;
            stop_in = 1'b0;
            rem_in  = '0;
            cnt_in  = '0;
            priority if (b == CH_PLUS) begin
               type_in  = TY_SIMPLE;
               phase_in = PH_TEXT;
            end else if (b == CH_COLON) begin
               type_in  = TY_INTEGER;
               phase_in = PH_TEXT;
            end else if (b == CH_DOLLAR) begin
               type_in  = TY_BULK;
               phase_in = PH_LEN;
            end else begin
               type_in          = TY_SIMPLE;
               res_a.is_status  = 1'b1;
               res_a.status     = ST_BAD;
               res_n            = 2'd1;
               decided          = 1'b1;
               phase_in         = fin_phase;
            end
         end

         PH_TEXT: begin
            if (hcr_ff && (b == CH_LF)) begin
               // End of value: empty value is malformed
               hcr_in          = 1'b0;
               res_a.is_status = 1'b1;
               res_a.status    = (cnt_ff == '0) ? ST_BAD : ST_OK;
               count_a         = (cnt_ff == '0) ? '0 : cnt_ff;
               res_n           = 2'd1;
               decided         = 1'b1;
               phase_in        = fin_phase;
            end else if (hcr_ff) begin
               // Lone CR: stream it, then handle this byte
               hcr_in          = 1'b0;
               res_a.data_byte = CH_CR;
               cnt_in          = cnt_inc;
               res_n           = 2'd2;
               priority if (b == CH_NUL) begin
                  res_b.is_status = 1'b1;
                  res_b.status    = ST_BAD;
                  decided         = 1'b1;
                  phase_in        = fin_phase;
               end else if (b == CH_CR) begin
                  hcr_in = 1'b1;
                  res_n  = 2'd1;
               end else begin
                  res_b.data_byte = b;
                  cnt_in          = cnt_inc2;
               end
            end else begin
               priority if (b == CH_NUL) begin
                  res_a.is_status = 1'b1;
                  res_a.status    = ST_BAD;
                  res_n           = 2'd1;
                  decided         = 1'b1;
                  phase_in        = fin_phase;
               end else if (b == CH_CR) begin
                  hcr_in = 1'b1;
               end else begin
                  res_a.data_byte = b;
                  cnt_in          = cnt_inc;
                  res_n           = 2'd1;
               end
            end
         end

         PH_LEN: begin
            if (hcr_ff && (b == CH_LF)) begin
               // Header complete: nil, bad negative, or a body length
               hcr_in = 1'b0;
               if ((lcnt_ff == LCW'(2)) && lneg_ff && (lval_ff == LENGTH_WIDTH'(1)) &&
                   !stop_ff) begin
                  if (at_end) begin
                     res_a.is_status = 1'b1;
                     res_a.status    = ST_NIL;
                     res_n           = 2'd1;
                     decided         = 1'b1;
                     phase_in        = fin_phase;
                  end else begin
                     phase_in = PH_NILWAIT;
                  end
               end else if (lneg_ff && (lval_ff != '0)) begin
                  res_a.is_status = 1'b1;
                  res_a.status    = ST_BAD;
                  res_n           = 2'd1;
                  decided         = 1'b1;
                  phase_in        = fin_phase;
               end else begin
                  rem_in   = lval_ff;
                  phase_in = (lval_ff != '0) ? PH_BODY : PH_TRAIL_CR;
               end
            end else if (hcr_ff) begin
               // Lone CR counts as a non-digit header character
               hcr_in  = 1'b0;
               lcnt_in = lcnt_p1;
               if (lcnt_p1 > LCNT_LIMIT) begin
                  res_a.is_status = 1'b1;
                  res_a.status    = ST_BAD;
                  res_n           = 2'd1;
                  decided         = 1'b1;
                  phase_in        = fin_phase;
               end else begin
                  stop_in = 1'b1;
                  priority if (b == CH_NUL) begin
                     res_a.is_status = 1'b1;
                     res_a.status    = ST_BAD;
                     res_n           = 2'd1;
                     decided         = 1'b1;
                     phase_in        = fin_phase;
                  end else if (b == CH_CR) begin
                     hcr_in = 1'b1;
                  end else begin
                     // Digits already stopped: only the count moves
                     lcnt_in = lcnt_p2;
                     if (lcnt_p2 > LCNT_LIMIT) begin
                        res_a.is_status = 1'b1;
                        res_a.status    = ST_BAD;
                        res_n           = 2'd1;
                        decided         = 1'b1;
                        phase_in        = fin_phase;
                     end
                  end
               end
            end else begin
               priority if (b == CH_NUL) begin
                  res_a.is_status = 1'b1;
                  res_a.status    = ST_BAD;
                  res_n           = 2'd1;
                  decided         = 1'b1;
                  phase_in        = fin_phase;
               end else if (b == CH_CR) begin
                  hcr_in = 1'b1;
               end else begin
                  lcnt_in = lcnt_p1;
                  priority if (lcnt_p1 > LCNT_LIMIT) begin
                     res_a.is_status = 1'b1;
                     res_a.status    = ST_BAD;
                     res_n           = 2'd1;
                     decided         = 1'b1;
                     phase_in        = fin_phase;
                  end else if ((lcnt_p1 == LCW'(1)) && ((b == CH_PLUS) || (b == CH_MINUS))) begin
                     lneg_in = (b == CH_MINUS);
                  end else if (!stop_ff && is_digit) begin
                     lval_in = lval_next;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
         end

         PH_NILWAIT: begin
            // Only a NUL after "-1" CR LF keeps the nil
            res_a.is_status = 1'b1;
            res_a.status    = (b == CH_NUL) ? ST_NIL : ST_BAD;
            res_n           = 2'd1;
            decided         = 1'b1;
            phase_in        = fin_phase;
         end

         PH_BODY: begin
            res_a.data_byte = b;
            cnt_in          = cnt_inc;
            res_n           = 2'd1;
            if (rem_ff <= LENGTH_WIDTH'(1)) begin
               rem_in   = '0;
               phase_in = PH_TRAIL_CR;
            end else begin
               rem_in = rem_ff - 1'b1;
            end
         end

         PH_TRAIL_CR: begin
            if (b == CH_CR) begin
               phase_in = PH_TRAIL_LF;
            end else begin
               res_a.is_status = 1'b1;
               res_a.status    = ST_BAD;
               res_n           = 2'd1;
               decided         = 1'b1;
               phase_in        = fin_phase;
            end
         end

         PH_TRAIL_LF: begin
            res_a.is_status = 1'b1;
            res_a.status    = (b == CH_LF) ? ST_OK : ST_BAD;
            count_a         = (b == CH_LF) ? lval_ff : '0;
            res_n           = 2'd1;
            decided         = 1'b1;
            phase_in        = fin_phase;
         end

         default: begin
            // Drop bytes of a decided reply until the buffer ends
            phase_in = fin_phase;
         end
      endcase

      // Buffer ended before the reply was decided: replace everything with one bad status
      if (at_end && !decided && (phase_ff != PH_SKIP)) begin
         res_a           = '0;
         res_a.is_status = 1'b1;
         res_a.status    = ST_BAD;
         count_a         = '0;
         res_n           = 2'd1;
         phase_in        = PH_IDLE;
      end

      res_a.reply_type = type_in;
      res_b.reply_type = type_in;
      res_a.last       = (res_n == 2'd1);
      res_b.last       = (res_n == 2'd2);
   end

   // Parser state: advance on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hcr_ff   <= 1'b0;
         type_ff  <= TY_SIMPLE;
         lval_ff  <= '0;
         lcnt_ff  <= '0;
         lneg_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         hcr_ff   <= hcr_in;
         type_ff  <= type_in;
         lval_ff  <= lval_in;
         lcnt_ff  <= lcnt_in;
         lneg_ff  <= lneg_in;
         stop_ff  <= stop_in;
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result register fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else if (take) begin
         fill_ff <= res_n;
      end else if (pop) begin
         fill_ff <= fill_ff - 1'b1;
      end
   end

   // Result register payload: load on input transfer, shift on output transfer
   always_ff @(posedge clock) begin
      if (take) begin
         slot0_ff  <= res_a;
         slot1_ff  <= res_b;
         count0_ff <= count_a;
         count1_ff <= count_b;
      end else if (pop) begin
         slot0_ff  <= slot1_ff;
         count0_ff <= count1_ff;
      end
   end

   assign rsp_is_status     = slot0_ff.is_status;
   assign rsp_data_byte     = slot0_ff.data_byte;
   assign rsp_reply_type    = slot0_ff.reply_type;
   assign rsp_status        = slot0_ff.status;
   assign rsp_payload_count = count0_ff;
   assign rsp_last          = slot0_ff.last;

endmodule
